// ----- design/lpct_pkg.sv -----
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared sizes for the LRU page cache tag engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lpct_pkg;

  // Cache geometry
  localparam int ENTRIES = 64;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int AGE_W   = SLOT_W;
  localparam int COUNT_W = $clog2(ENTRIES + 1);

  // Field widths of the ports
  localparam int PAGE_W      = 32;
  localparam int TAG_W       = 32;
  localparam int CAP_W       = 7;
  localparam int SLOT_OUT_W  = 6;
  localparam int OCC_OUT_W   = 7;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef logic [ENTRIES-1:0] entry_vec_t;

endpackage : lpct_pkg

`default_nettype wire

// ----- design/lru_page_cache_tags.sv -----
// ----------------------------------------------------------------------------
// lru_page_cache_tags
// Tag and replacement engine of a fully associative page cache with LRU
// replacement. Tags, valid marks and recency ranks live in flops and are
// searched in parallel for every request.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   request   | start_i / busy_o     | page_number_i
//   result    | done_o (strobe)      | hit_o, slot_o, evicted_o,
//             |                      | evicted_page_o, occupancy_o
//   config    | cfg_we_i             | cfg_wdata_i (capacity_pages)
//
// One request per cycle. The request is registered, then one pass of
// parallel tag compare, rank compare and rank update runs before the
// result and state registers. busy_o stays low: every cycle takes a
// request. Reset clears valid marks, ranks and occupancy at once; no
// clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_cache_tags (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  output logic                                   busy_o,
  input  wire logic [lpct_pkg::PAGE_W-1:0]       page_number_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lpct_pkg::CAP_W-1:0]        cfg_wdata_i,
  output logic                                   done_o,
  output logic                                   hit_o,
  output logic [lpct_pkg::SLOT_OUT_W-1:0]        slot_o,
  output logic                                   evicted_o,
  output logic [lpct_pkg::TAG_W-1:0]             evicted_page_o,
  output logic [lpct_pkg::OCC_OUT_W-1:0]         occupancy_o
);

  import lpct_pkg::*;

  // Request register
  logic               req_q;
  logic [TAG_W-1:0]   page_q;

  // Configuration
  logic [CAP_W-1:0]   cap_q;

  // Entry state
  entry_vec_t         valid_q, valid_d;
  logic [AGE_W-1:0]   age_q [ENTRIES];
  logic [AGE_W-1:0]   age_d [ENTRIES];
  logic [TAG_W-1:0]   tag_q [ENTRIES];
  logic [COUNT_W-1:0] count_q, count_d;

  // Lookup results
  entry_vec_t         hit_vec, free_vec, free_first, victim_vec, take_vec, sel_vec;
  logic               hit;
  logic               full;
  logic               evict;
  logic [AGE_W-1:0]   old_age;
  logic [SLOT_W-1:0]  slot_idx;
  logic [TAG_W-1:0]   victim_tag;
  logic [COUNT_W-1:0] eff_cap;
  logic [COUNT_W-1:0] lru_rank;

  // Result registers
  logic                  done_q;
  logic                  hit_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  evicted_q;
  logic [TAG_W-1:0]      evicted_page_q;
  logic [COUNT_W-1:0]    occ_q;

  // A request is taken every cycle
  assign busy_o = 1'b0;

  // Request register and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
      cap_q <= CAP_RESET;
    end else begin
      req_q <= start_i && !busy_o;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      page_q <= TAG_W'(page_number_i);
    end
  end

  // Effective capacity: zero acts as one, saturate at the entry count
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = COUNT_W'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      eff_cap = COUNT_W'(ENTRIES);
    end else begin
      eff_cap = COUNT_W'(cap_q);
    end
  end

  // Parallel tag and rank compare; the LRU entry holds the top rank
  assign lru_rank = count_q - COUNT_W'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = valid_q[i] && (tag_q[i] == page_q);
      free_vec[i]   = !valid_q[i];
      victim_vec[i] = valid_q[i] && (COUNT_W'(age_q[i]) == lru_rank);
    end
  end

  assign hit        = |hit_vec;
  assign full       = count_q >= eff_cap;
  assign evict      = !hit && full;
  assign free_first = free_vec & (~free_vec + entry_vec_t'(1));
  assign take_vec   = evict ? victim_vec : free_first;
  assign sel_vec    = hit ? hit_vec : take_vec;

  // One-hot reads: rank of the hit entry, victim tag, slot index
  always_comb begin
    old_age    = '0;
    victim_tag = '0;
    slot_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      old_age    = old_age | (hit_vec[i] ? age_q[i] : '0);
      victim_tag = victim_tag | (victim_vec[i] ? tag_q[i] : '0);
      slot_idx   = slot_idx | (sel_vec[i] ? SLOT_W'(i) : '0);
    end
  end

  // Next valid marks, ranks and occupancy
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < ENTRIES; i++) begin
      age_d[i] = age_q[i];
    end
    if (req_q) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            age_d[i] = '0;
          end else if (valid_q[i] && (age_q[i] < old_age)) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (take_vec[i]) begin
            valid_d[i] = 1'b1;
            age_d[i]   = '0;
          end else if (valid_q[i]) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
        // Eviction frees one entry and the new page fills it
        if (!evict) begin
          count_d = count_q + COUNT_W'(1);
        end
      end
    end
  end

  // Entry state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= age_d[i];
      end
    end
  end

  // Tag write on a miss
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (req_q && !hit && take_vec[i]) begin
        tag_q[i] <= page_q;
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_q) begin
      hit_q          <= hit;
      slot_q         <= slot_idx;
      evicted_q      <= evict;
      evicted_page_q <= evict ? victim_tag : '0;
      occ_q          <= count_d;
    end
  end

  assign done_o         = done_q;
  assign hit_o          = hit_q;
  assign slot_o         = SLOT_OUT_W'(slot_q);
  assign evicted_o      = evicted_q;
  assign evicted_page_o = evicted_page_q;
  assign occupancy_o    = OCC_OUT_W'(occ_q);

endmodule : lru_page_cache_tags

`default_nettype wire
